// ----- hw/rtl/fsfla_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed-slot free-list allocator package
// Shared widths, codes and the result record of the slot allocator.
// ----------------------------------------------------------------------------
package fsfla_pkg;

	localparam int ADDR_W   = 48;
	localparam int CNT_W    = 11;
	localparam int SHIFT_W  = 5;
	localparam int CFG_W    = 48;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SHIFT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_SLOTS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ALL_FREE    = 2'd3;

	typedef enum logic {
		FSM_IDLE,
		FSM_POP
	} fsm_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   slot_address;
		logic [CNT_W-1:0]    slots_free;
	} result_t;

endpackage

// ----- hw/rtl/fixed_slot_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Fixed-slot free-list allocator
// Hands out and takes back equal-sized slots of one pool through a LIFO free
// list whose links live in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel (in_valid/in_ready) is an allocate or a
// free, and produces exactly one response on the output channel
// (out_valid/out_ready) carrying status, slot_address and slots_free.
// The response is registered at the edge that accepts the request. A free, a
// fresh allocate and any rejected request leave the block ready for the next
// request while the output buffer has room. An allocate that pops the free
// list also enters a wait state: the link of the top slot is read into the
// registered read port of the link memory, and no request is taken until the new list head is loaded from it.
// The output side has a main register and a skid register, so a request is
// still taken while one response waits; with both full, in_ready drops until
// the receiver takes a response.
// Reset clears the list, sets the free count to the effective slot count and
// loads the register defaults; the link memory is not cleared and needs no
// clearing pass. Writing slot_count reloads the pool the same way.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_top #(
	parameter int SLOTS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [fsfla_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsfla_pkg::CFG_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [fsfla_pkg::ADDR_W-1:0]       free_address,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fsfla_pkg::STATUS_W-1:0]     status,
	output logic [fsfla_pkg::ADDR_W-1:0]       slot_address,
	output logic [fsfla_pkg::CNT_W-1:0]        slots_free
);
	import fsfla_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'((SLOTS < 1024) ? SLOTS : 1024);

	// Configuration and allocator state
	logic [ADDR_W-1:0]  region_start_q;
	logic [SHIFT_W-1:0] slot_shift_q;
	logic [CNT_W-1:0]   slot_count_q;
	logic [IDX_W-1:0]   head_q;
	logic               nonempty_q;
	logic [CNT_W-1:0]   fresh_q;
	logic [CNT_W-1:0]   free_q;
	fsm_t               state_q, state_d;

	// Link memory
	logic [IDX_W-1:0]   link_mem [SLOTS];
	logic [IDX_W-1:0]   link_rd_q;

	// Output buffer
	result_t            main_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	logic               acc;
	logic [CNT_W-1:0]   count;
	logic [CNT_W-1:0]   cfg_count;
	logic               head_ok;
	logic               pop_ok;
	logic               fresh_ok;
	logic [IDX_W-1:0]   alloc_idx;
	logic [ADDR_W-1:0]  offset;
	logic [ADDR_W-1:0]  free_idx_wide;
	logic [IDX_W-1:0]   free_idx;
	logic               in_range;
	logic               all_free;
	logic               do_pop;
	logic               do_fresh;
	logic               do_push;
	result_t            res;

	assign acc = in_valid && in_ready;

	// Slot counts above the memory depth behave as the memory depth.
	always_comb begin
		if (32'(slot_count_q) > SLOTS) begin
			count = CNT_W'(SLOTS);
		end else begin
			count = slot_count_q;
		end
		if (32'(cfg_data[CNT_W-1:0]) > SLOTS) begin
			cfg_count = CNT_W'(SLOTS);
		end else begin
			cfg_count = cfg_data[CNT_W-1:0];
		end
	end

	always_comb begin
		head_ok   = 32'(head_q) < SLOTS;
		pop_ok    = nonempty_q && head_ok && (free_q != '0);
		fresh_ok  = (fresh_q < count) && (free_q != '0);
		alloc_idx = pop_ok ? head_q : IDX_W'(fresh_q);

		offset        = free_address - region_start_q;
		free_idx_wide = offset >> slot_shift_q;
		free_idx      = free_idx_wide[IDX_W-1:0];
		in_range      = free_idx_wide < ADDR_W'(count);
		all_free      = free_q >= count;

		do_pop   = acc && (command == CMD_ALLOC) && pop_ok;
		do_fresh = acc && (command == CMD_ALLOC) && !pop_ok && fresh_ok;
		do_push  = acc && (command == CMD_FREE) && in_range && !all_free;

		res.slot_address = '0;
		res.slots_free   = free_q;
		if (command == CMD_ALLOC) begin
			if (pop_ok || fresh_ok) begin
				res.status       = ST_OK;
				res.slot_address = region_start_q + (ADDR_W'(alloc_idx) << slot_shift_q);
				res.slots_free   = free_q - 1'b1;
			end else begin
				res.status = ST_OUT_OF_SLOTS;
			end
		end else begin
			if (!in_range) begin
				res.status = ST_BAD_ADDR;
			end else if (all_free) begin
				res.status = ST_ALL_FREE;
			end else begin
				res.status     = ST_OK;
				res.slots_free = free_q + 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (do_pop) begin
					state_d = FSM_POP;
				end
			end
			FSM_POP: begin
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		unique case (state_q)
			FSM_IDLE: in_ready = !skid_valid_q;
			FSM_POP:  in_ready = 1'b0;
			default:  in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= FSM_IDLE;
			region_start_q <= '0;
			slot_shift_q   <= SHIFT_W'(4);
			slot_count_q   <= CNT_W'(1024);
			head_q         <= '0;
			nonempty_q     <= 1'b0;
			fresh_q        <= '0;
			free_q         <= RESET_COUNT;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_REGION_START: region_start_q <= cfg_data[ADDR_W-1:0];
					REG_SLOT_SHIFT:   slot_shift_q   <= cfg_data[SHIFT_W-1:0];
					REG_SLOT_COUNT: begin
						slot_count_q <= cfg_data[CNT_W-1:0];
						head_q       <= '0;
						nonempty_q   <= 1'b0;
						fresh_q      <= '0;
						free_q       <= cfg_count;
					end
					default: begin
					end
				endcase
			end else if (state_q == FSM_POP) begin
				// The popped slot's link is now in the read register.
				head_q <= link_rd_q;
			end else if (do_pop) begin
				free_q     <= free_q - 1'b1;
				nonempty_q <= (free_q - 1'b1) > (count - fresh_q);
			end else if (do_fresh) begin
				free_q  <= free_q - 1'b1;
				fresh_q <= fresh_q + 1'b1;
			end else if (do_push) begin
				head_q     <= free_idx;
				nonempty_q <= 1'b1;
				free_q     <= free_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			link_mem[free_idx] <= head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			link_rd_q <= link_mem[head_q];
		end
	end

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!acc) begin
					out_valid_q <= 1'b0;
				end
			end else if (acc) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	// Output buffer data
	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (acc) begin
				main_q <= res;
			end
		end else if (acc) begin
			if (!out_valid_q) begin
				main_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = main_q.status;
	assign slot_address = main_q.slot_address;
	assign slots_free   = main_q.slots_free;

	// The free count never exceeds the pool size.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= count)
		else $error("free count above pool size");

	// Fresh slots handed out never exceed the pool size.
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= count)
		else $error("fresh mark above pool size");

	// The pop wait state only follows an accepted allocate.
	a_pop_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_POP) |-> $past(acc && (command == CMD_ALLOC)))
		else $error("pop state without an allocate");

	// The skid register is only filled behind a full main register.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a response ahead of the main register");

endmodule

// ----- tb/sv/fixed_slot_free_list_allocator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator response checker
// Watches the configuration port and both request and response channels,
// keeps its own copy of the free list and the pool registers, works out the
// response of every accepted request and compares it with what the block
// returns, field by field and in order.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_checker #(
	parameter int SLOTS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [fsfla_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsfla_pkg::CFG_W-1:0]        cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               command,
	input  logic [fsfla_pkg::ADDR_W-1:0]       free_address,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [fsfla_pkg::STATUS_W-1:0]     status,
	input  logic [fsfla_pkg::ADDR_W-1:0]       slot_address,
	input  logic [fsfla_pkg::CNT_W-1:0]        slots_free,
	output int                                 errors,
	output int                                 outstanding
);
	import fsfla_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic [ADDR_W-1:0]  region_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [CNT_W-1:0]   count_q;

	logic [IDX_W-1:0]   link_mem [SLOTS];
	logic [IDX_W-1:0]   list_head;
	logic               list_nonempty;
	logic [CNT_W-1:0]   fresh_mark;
	logic [CNT_W-1:0]   free_total;

	result_t            expected_q [$];
	result_t            want;

	// Register values above the pool capacity behave as the full capacity.
	function automatic logic [CNT_W-1:0] pool_size();
		return (count_q > SLOTS) ? CNT_W'(SLOTS) : count_q;
	endfunction

	task automatic reload_pool();
		list_head = '0;
		list_nonempty = 1'b0;
		fresh_mark = '0;
		free_total = pool_size();
	endtask

	task automatic predict_response(input logic cmd, input logic [ADDR_W-1:0] addr);
		logic [CNT_W-1:0]  size;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] slot;
		logic [IDX_W-1:0]  idx;
		logic              granted;
		result_t           r;
		size = pool_size();
		r = '0;
		r.status = ST_OK;
		granted = 1'b0;
		idx = '0;
		if (cmd == CMD_ALLOC) begin
			if (list_nonempty && free_total != 0) begin
				idx = list_head;
				list_head = link_mem[idx];
				free_total = free_total - 1'b1;
				// The list still holds slots while the free count exceeds the
				// never-used slots that remain.
				list_nonempty = free_total > (size - fresh_mark);
				granted = 1'b1;
			end else if (fresh_mark < size && free_total != 0) begin
				idx = fresh_mark[IDX_W-1:0];
				fresh_mark = fresh_mark + 1'b1;
				free_total = free_total - 1'b1;
				granted = 1'b1;
			end
			if (granted)
				r.slot_address = region_q + (ADDR_W'(idx) << shift_q);
			else
				r.status = ST_OUT_OF_SLOTS;
		end else begin
			offset = addr - region_q;
			slot = offset >> shift_q;
			if (slot >= ADDR_W'(size)) begin
				r.status = ST_BAD_ADDR;
			end else if (free_total >= size) begin
				r.status = ST_ALL_FREE;
			end else begin
				link_mem[slot[IDX_W-1:0]] = list_head;
				list_head = slot[IDX_W-1:0];
				list_nonempty = 1'b1;
				free_total = free_total + 1'b1;
			end
		end
		r.slots_free = free_total;
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q = '0;
			shift_q = SHIFT_W'(4);
			count_q = CNT_W'(1024);
			foreach (link_mem[i])
				link_mem[i] = '0;
			reload_pool();
			expected_q.delete();
			outstanding = 0;
		end else begin
			// Responses first: a response never belongs to a request taken
			// at the same edge.
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$error("unexpected response: status %0d slot_address %h slots_free %0d",
						status, slot_address, slots_free);
				end else begin
					want = expected_q.pop_front();
					if (status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, status);
					end
					if (slot_address !== want.slot_address) begin
						errors++;
						$error("slot_address: expected %h, got %h",
							want.slot_address, slot_address);
					end
					if (slots_free !== want.slots_free) begin
						errors++;
						$error("slots_free: expected %0d, got %0d", want.slots_free, slots_free);
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_REGION_START: begin
						region_q = cfg_data[ADDR_W-1:0];
					end
					REG_SLOT_SHIFT: begin
						shift_q = cfg_data[SHIFT_W-1:0];
					end
					REG_SLOT_COUNT: begin
						count_q = cfg_data[CNT_W-1:0];
						reload_pool();
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				predict_response(command, free_address);
			outstanding = expected_q.size();
		end
	end

endmodule

// ----- tb/sv/fixed_slot_free_list_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate and free requests into the allocator under changing pool
// settings, with random gaps and response back-pressure, and lets the
// checker compare every response against its own prediction.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_top_tb;
	import fsfla_pkg::*;

	localparam int SLOTS       = 1024;
	localparam int RANDOM_REQS = 1250;
	localparam int STALL_LIMIT = 5000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic [ADDR_W-1:0]    free_address;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status;
	logic [ADDR_W-1:0]    slot_address;
	logic [CNT_W-1:0]     slots_free;

	int                   errors;
	int                   outstanding;
	int                   quiet_cycles;

	// Pool settings as last written, used to aim frees at real slots.
	logic [ADDR_W-1:0]    cur_region;
	logic [SHIFT_W-1:0]   cur_shift;
	int                   cur_size;
	bit                   in_steady;
	bit                   out_steady;

	logic                 issued_cmds [$];
	logic [ADDR_W-1:0]    live_addrs [$];

	fixed_slot_free_list_allocator_top #(.SLOTS(SLOTS)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.free_address (free_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_address (slot_address),
		.slots_free   (slots_free)
	);

	fixed_slot_free_list_allocator_checker #(.SLOTS(SLOTS)) alloc_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.free_address (free_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_address (slot_address),
		.slots_free   (slots_free),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly returns a slot that is really out, with random bits inside the
	// slot; otherwise double frees, addresses just past either end, or noise.
	function automatic logic [ADDR_W-1:0] pick_free_address();
		logic [ADDR_W-1:0] low;
		int r;
		int k;
		low = rand_addr() & ((ADDR_W'(1) << cur_shift) - 1'b1);
		r = $urandom_range(0, 99);
		if (r < 60 && live_addrs.size() != 0) begin
			k = $urandom_range(0, live_addrs.size() - 1);
			pick_free_address = live_addrs[k] + low;
			live_addrs.delete(k);
		end else if (r < 80) begin
			pick_free_address = cur_region
				+ (ADDR_W'($urandom_range(0, cur_size)) << cur_shift) + low;
		end else if (r < 88) begin
			pick_free_address = cur_region - 1'b1 - low;
		end else begin
			pick_free_address = rand_addr();
		end
	endfunction

	// Called and returns on a falling edge; valid stays high between
	// back-to-back requests.
	task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = pick_gap(in_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		free_address <= addr;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic configure(input logic [ADDR_W-1:0] region, input logic [SHIFT_W-1:0] shift,
			input logic [CNT_W-1:0] count);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		// A popping allocate may still be loading the new list head.
		repeat (4) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_REGION_START;
		cfg_data <= CFG_W'(region);
		@(negedge clk);
		cfg_index <= REG_SLOT_SHIFT;
		cfg_data <= CFG_W'(shift);
		@(negedge clk);
		cfg_index <= REG_SLOT_COUNT;
		cfg_data <= CFG_W'(count);
		@(negedge clk);
		cfg_write <= 1'b0;
		cur_region = region;
		cur_shift = shift;
		cur_size = (count > SLOTS) ? SLOTS : int'(count);
		live_addrs.delete();
	endtask

	// Tracks which slots are handed out so frees can return them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready && issued_cmds.size() != 0) begin
				if (issued_cmds.pop_front() == CMD_ALLOC && status == ST_OK)
					live_addrs.push_back(slot_address);
			end
			if (in_valid && in_ready)
				issued_cmds.push_back(command);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("fixed_slot_free_list_allocator_top_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
			stall = pick_gap(out_steady);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	initial begin
		int total;
		int n;
		int alloc_pct;
		int r;
		logic [ADDR_W-1:0]  region;
		logic [SHIFT_W-1:0] shift;
		logic [CNT_W-1:0]   count;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_REGION_START;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_ALLOC;
		free_address = '0;
		cur_region = '0;
		cur_shift = SHIFT_W'(4);
		cur_size = SLOTS;
		in_steady = 1'b0;
		out_steady = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: the whole pool is free, so an in-range free is refused.
		send_request(CMD_FREE, '0);
		send_request(CMD_FREE, '1);
		send_request(CMD_FREE, ADDR_W'(SLOTS) << 4);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_ALLOC, '1);
		send_request(CMD_FREE, ADDR_W'('h1F));
		send_request(CMD_FREE, ADDR_W'('h3FF0));
		send_request(CMD_ALLOC, '0);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_ALLOC, '0);

		// Tiny pool that wraps past the top of the address space.
		configure(48'hFFFF_FFFF_FFF0, SHIFT_W'(3), CNT_W'(3));
		repeat (4) send_request(CMD_ALLOC, '0);
		send_request(CMD_FREE, ADDR_W'('h7));
		send_request(CMD_FREE, 48'hFFFF_FFFF_FFEF);
		send_request(CMD_ALLOC, '0);

		// Empty pool.
		configure('0, '0, '0);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_FREE, '0);

		// Oversized count, widest shift, region at the very top.
		configure('1, SHIFT_W'(31), '1);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_FREE, 48'hFFFF_FFFF_FFFF + (ADDR_W'(1) << 31));
		send_request(CMD_FREE, 48'hFFFF_FFFF_FFFF + (ADDR_W'(1023) << 31) + 48'h7FFF_FFFF);
		send_request(CMD_ALLOC, '0);
		send_request(CMD_FREE, '0);

		total = 0;
		while (total < RANDOM_REQS) begin
			r = $urandom_range(0, 3);
			if (r == 0)
				region = '0;
			else if (r == 1)
				region = 48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 4095));
			else
				region = rand_addr();
			r = $urandom_range(0, 9);
			if (r == 0)
				shift = SHIFT_W'($urandom_range(0, 2));
			else if (r == 1)
				shift = SHIFT_W'($urandom_range(25, 31));
			else
				shift = SHIFT_W'($urandom_range(3, 24));
			r = $urandom_range(0, 9);
			if (r < 6)
				count = CNT_W'($urandom_range(1, 16));
			else if (r == 6)
				count = '0;
			else if (r == 7)
				count = CNT_W'(SLOTS);
			else if (r == 8)
				count = CNT_W'($urandom_range(SLOTS + 1, 2047));
			else
				count = CNT_W'($urandom_range(17, SLOTS - 1));
			configure(region, shift, count);
			in_steady = ($urandom_range(0, 4) == 0);
			out_steady = ($urandom_range(0, 4) == 0);
			alloc_pct = $urandom_range(25, 75);
			n = $urandom_range(20, 80);
			repeat (n) begin
				if ($urandom_range(0, 99) < alloc_pct)
					send_request(CMD_ALLOC, rand_addr());
				else
					send_request(CMD_FREE, pick_free_address());
				total++;
			end
		end

		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("fixed_slot_free_list_allocator_top_tb: done, clean");
		else
			$display("fixed_slot_free_list_allocator_top_tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/fsfla_pkg.sv
hw/rtl/fixed_slot_free_list_allocator_top.sv
tb/sv/fixed_slot_free_list_allocator_checker.sv
tb/sv/fixed_slot_free_list_allocator_top_tb.sv
